@@ design/vwbp_pkg.sv @@
// Shared types and constants for the variable-width bit packer.
// No dependencies; used by every module of the packer.
package vwbp_pkg;

    // Widest value width the packer accepts
    localparam int unsigned MAX_BITS = 16;
    // Width register after reset
    localparam logic [4:0] BPV_RESET = 5'd8;

    // Job queue between the front and the back
    localparam int unsigned JOB_DEPTH = 4;
    localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);

    // One packing job: up to three bytes taken from acc, low byte first
    typedef struct packed {
        logic [23:0] acc;
        logic [1:0]  count;
        logic        last;
        logic        err;
    } t_job;

endpackage

@@ design/vwbp_front.sv @@
// Front end of the packer: takes input words, holds the leftover bits and
// the width register, and turns each word into a byte job. Uses vwbp_pkg.
module vwbp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [4:0]         i_cfg_wr_data,
    input  logic               i_take,
    input  logic [15:0]        i_value,
    input  logic               i_last_value,
    output logic               o_job_push,
    output vwbp_pkg::t_job     o_job
);

    logic [4:0]  r_bpv;
    logic [6:0]  r_leftover, n_leftover;
    logic [2:0]  r_fill, n_fill;
    logic        r_discard, n_discard;

    logic        width_ok;
    logic        value_ok;
    logic [22:0] acc;
    logic [4:0]  nbits;
    logic [1:0]  nfull;
    logic        pad;

    // Range checks on the width register and the value
    assign width_ok = (r_bpv != 5'd0) && (r_bpv <= 5'(vwbp_pkg::MAX_BITS));
    assign value_ok = ((i_value >> r_bpv) == 16'd0);

    // Append the value above the pending bits
    assign acc   = 23'(r_leftover) | (23'(i_value) << r_fill);
    assign nbits = 5'(r_fill) + r_bpv;
    assign nfull = nbits[4:3];
    assign pad   = i_last_value && (nbits[2:0] != 3'd0);

    // Job and next state
    always_comb begin
        n_leftover = r_leftover;
        n_fill     = r_fill;
        n_discard  = r_discard;
        o_job_push = 1'b0;
        o_job      = '0;
        if (i_take) begin
            if (r_discard) begin
                if (i_last_value) begin
                    n_discard = 1'b0;
                end
            end else if (!width_ok || !value_ok) begin
                o_job_push  = 1'b1;
                o_job.acc   = '0;
                o_job.count = 2'd1;
                o_job.last  = 1'b1;
                o_job.err   = 1'b1;
                n_leftover  = '0;
                n_fill      = '0;
                n_discard   = !i_last_value;
            end else begin
                o_job.acc   = 24'(acc);
                o_job.count = nfull + 2'(pad);
                o_job.last  = i_last_value;
                o_job.err   = 1'b0;
                o_job_push  = (o_job.count != 2'd0);
                if (i_last_value) begin
                    n_leftover = '0;
                    n_fill     = '0;
                end else begin
                    n_fill = nbits[2:0];
                    case (nfull)
                        2'd0:    n_leftover = acc[6:0];
                        2'd1:    n_leftover = acc[14:8];
                        2'd2:    n_leftover = acc[22:16];
                        default: n_leftover = '0;
                    endcase
                end
            end
        end
    end

    // State and width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpv      <= vwbp_pkg::BPV_RESET;
            r_leftover <= '0;
            r_fill     <= '0;
            r_discard  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_bpv <= i_cfg_wr_data;
            end
            r_leftover <= n_leftover;
            r_fill     <= n_fill;
            r_discard  <= n_discard;
        end
    end

endmodule

@@ design/vwbp_job_fifo.sv @@
// Short job queue between the packer front and back ends.
// Uses vwbp_pkg for the job type and depth.
module vwbp_job_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  vwbp_pkg::t_job     i_job,
    input  logic               i_pop,
    output vwbp_pkg::t_job     o_job,
    output logic               o_full,
    output logic               o_empty
);

    vwbp_pkg::t_job r_mem [vwbp_pkg::JOB_DEPTH];
    logic [vwbp_pkg::JOB_PTR_W-1:0] r_wr_ptr;
    logic [vwbp_pkg::JOB_PTR_W-1:0] r_rd_ptr;
    logic [vwbp_pkg::JOB_PTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (vwbp_pkg::JOB_PTR_W+1)'(vwbp_pkg::JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (vwbp_pkg::JOB_PTR_W+1)'(do_push)
                               - (vwbp_pkg::JOB_PTR_W+1)'(do_pop);
        end
    end

endmodule

@@ design/vwbp_back.sv @@
// Back end of the packer: takes queued jobs and, while pop keeps up, sends
// their bytes one per cycle via a registered output word. Uses vwbp_pkg.
module vwbp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vwbp_pkg::t_job     i_job,
    input  logic               i_job_empty,
    output logic               o_job_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_last,
    output logic               o_error
);

    logic        r_busy;
    logic [23:0] r_acc;
    logic [1:0]  r_left;
    logic        r_last;
    logic        r_err;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_err;

    logic        advance;
    logic        finishing;

    assign advance   = !r_out_valid || i_pop;
    assign finishing = r_busy && advance && (r_left == 2'd1);
    assign o_job_pop = !i_job_empty && (!r_busy || finishing);

    assign o_empty     = !r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_byte_last = r_out_last;
    assign o_error     = r_out_err;

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_busy;
        end
        if (advance && r_busy) begin
            r_out_byte <= r_acc[7:0];
            r_out_last <= r_last && (r_left == 2'd1);
            r_out_err  <= r_err;
        end
    end

    // Current job: load from the queue, shift out one byte per step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_job_pop) begin
            r_busy <= 1'b1;
        end else if (finishing) begin
            r_busy <= 1'b0;
        end
        if (o_job_pop) begin
            r_acc  <= i_job.acc;
            r_left <= i_job.count;
            r_last <= i_job.last;
            r_err  <= i_job.err;
        end else if (r_busy && advance) begin
            r_acc  <= r_acc >> 8;
            r_left <= r_left - 2'd1;
        end
    end

endmodule

@@ design/variable_width_bit_packer_unit.sv @@
// LSB-first variable-width bit packer, top level.
// Depends on vwbp_pkg, vwbp_front, vwbp_job_fifo and vwbp_back.
// Usage:
//   Input words (i_value, i_last_value) enter with push while full is low.
//   Each value adds bits_per_value bits above the pending bits; every
//   complete byte comes out on o_out_byte, earliest bits at bit 0. A word
//   with i_last_value set flushes a zero-padded partial byte and marks the
//   final byte with o_byte_last. An out-of-range value or width gives one
//   word with o_error and o_byte_last set, and words are dropped up to the
//   next i_last_value.
//   Output words wait on the ports while empty is low; pop takes one.
//   The width register is written with i_cfg_wr_en / i_cfg_wr_data.
// Timing:
//   A word's first byte shows after the job queue, job register and output
//   register. The back sends one byte per cycle while pop keeps up; a word
//   makes 0 to 2 at widths up to 8, up to 3 at 16 (2 plus the flush byte).
//   The front takes one word per cycle while full is low (4-entry queue).
// Reset: clears pending bits, the queue and the output; width becomes 8.
// Stall: when pop stays low the output word holds, the back stops, the
//   queue fills and full rises; nothing is lost.
module variable_width_bit_packer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [4:0]  i_cfg_wr_data,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_value,
    input  logic        i_last_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_last,
    output logic        o_error
);

    vwbp_pkg::t_job job_in;
    vwbp_pkg::t_job job_out;
    logic           job_push;
    logic           job_pop;
    logic           job_full;
    logic           job_empty;
    logic           take;

    assign full = job_full;
    assign take = push && !job_full;

    // Front: state and job build
    vwbp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_take        (take),
        .i_value       (i_value),
        .i_last_value  (i_last_value),
        .o_job_push    (job_push),
        .o_job         (job_in)
    );

    // Job queue
    vwbp_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_full  (job_full),
        .o_empty (job_empty)
    );

    // Back: byte emission
    vwbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out_byte  (o_out_byte),
        .o_byte_last (o_byte_last),
        .o_error     (o_error)
    );

endmodule
